FILE: hdl/dsag_pkg.sv
// shared types and constants of the dimension swap address generator
`timescale 1ns / 1ps
`default_nettype none

package dsag_pkg;

    // fixed field widths
    localparam int SIZE_WIDTH  = 21;
    localparam int INDEX_WIDTH = 20;
    localparam int OUT_ADDR_WIDTH = 20;
    localparam int DATA_WIDTH  = 32;
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 4;
    localparam int REG_SEL_WIDTH  = 2;

    // register indexes
    localparam logic [REG_SEL_WIDTH-1:0] REG_SIZE_FIRST    = 2'd0;
    localparam logic [REG_SEL_WIDTH-1:0] REG_SIZE_MIDDLE   = 2'd1;
    localparam logic [REG_SEL_WIDTH-1:0] REG_SIZE_SWAP     = 2'd2;
    localparam logic [REG_SEL_WIDTH-1:0] REG_ELEMENT_COUNT = 2'd3;

    // configuration sizes as seen by the address unit
    typedef struct packed {
        logic [SIZE_WIDTH-1:0] size_first;
        logic [SIZE_WIDTH-1:0] size_middle;
        logic [SIZE_WIDTH-1:0] size_swap;
        logic [SIZE_WIDTH-1:0] element_count;
    } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/dsag_cfg.sv
// apb register file with precomputed address strides
`timescale 1ns / 1ps
`default_nettype none

module dsag_cfg
    import dsag_pkg::*;
#(
    parameter int ADDR_WIDTH = 20
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic      [APB_DATA_WIDTH-1:0] prdata,
    output logic                           pready,
    output cfg_t                           cfg,
    output logic      [ADDR_WIDTH-1:0]     mid_swap,
    output logic      [ADDR_WIDTH-1:0]     block_step
);

    logic [REG_SEL_WIDTH-1:0] reg_sel;
    logic                     wr_en;

    logic [SIZE_WIDTH-1:0] size_first_reg,    size_first_next;
    logic [SIZE_WIDTH-1:0] size_middle_reg,   size_middle_next;
    logic [SIZE_WIDTH-1:0] size_swap_reg,     size_swap_next;
    logic [SIZE_WIDTH-1:0] element_count_reg, element_count_next;

    logic [ADDR_WIDTH-1:0] mid_swap_reg,   mid_swap_next;
    logic [ADDR_WIDTH-1:0] first_mid_reg,  first_mid_next;
    logic [ADDR_WIDTH-1:0] block_step_reg, block_step_next;

    logic [2*SIZE_WIDTH-1:0]        ms_full;
    logic [2*SIZE_WIDTH-1:0]        fm_full;
    logic [ADDR_WIDTH+SIZE_WIDTH-1:0] bs_full;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_WIDTH-1:2];
    assign wr_en   = psel && penable && pwrite;

    // register writes
    always_comb
    begin
        size_first_next    = size_first_reg;
        size_middle_next   = size_middle_reg;
        size_swap_next     = size_swap_reg;
        element_count_next = element_count_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_SIZE_FIRST:    size_first_next    = pwdata[SIZE_WIDTH-1:0];
                REG_SIZE_MIDDLE:   size_middle_next   = pwdata[SIZE_WIDTH-1:0];
                REG_SIZE_SWAP:     size_swap_next     = pwdata[SIZE_WIDTH-1:0];
                REG_ELEMENT_COUNT: element_count_next = pwdata[SIZE_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    // mid_swap uses new sizes, ready with the register; block_step lags
    always_comb
    begin
        ms_full         = size_middle_next * size_swap_next;
        fm_full         = size_first_next * size_middle_next;
        mid_swap_next   = ms_full[ADDR_WIDTH-1:0];
        first_mid_next  = fm_full[ADDR_WIDTH-1:0];
        bs_full         = first_mid_reg * size_swap_reg;
        block_step_next = bs_full[ADDR_WIDTH-1:0];
    end

    // read back
    always_comb
    begin
        case (reg_sel)
            REG_SIZE_FIRST:    prdata = APB_DATA_WIDTH'(size_first_reg);
            REG_SIZE_MIDDLE:   prdata = APB_DATA_WIDTH'(size_middle_reg);
            REG_SIZE_SWAP:     prdata = APB_DATA_WIDTH'(size_swap_reg);
            REG_ELEMENT_COUNT: prdata = APB_DATA_WIDTH'(element_count_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_first_reg    <= SIZE_WIDTH'(1);
            size_middle_reg   <= SIZE_WIDTH'(1);
            size_swap_reg     <= SIZE_WIDTH'(1);
            element_count_reg <= SIZE_WIDTH'(1);
            mid_swap_reg      <= ADDR_WIDTH'(1);
            first_mid_reg     <= ADDR_WIDTH'(1);
            block_step_reg    <= ADDR_WIDTH'(1);
        end
        else
        begin
            size_first_reg    <= size_first_next;
            size_middle_reg   <= size_middle_next;
            size_swap_reg     <= size_swap_next;
            element_count_reg <= element_count_next;
            mid_swap_reg      <= mid_swap_next;
            first_mid_reg     <= first_mid_next;
            block_step_reg    <= block_step_next;
        end
    end

    assign cfg.size_first    = size_first_reg;
    assign cfg.size_middle   = size_middle_reg;
    assign cfg.size_swap     = size_swap_reg;
    assign cfg.element_count = element_count_reg;
    assign mid_swap          = mid_swap_reg;
    assign block_step        = block_step_reg;

endmodule

`default_nettype wire

FILE: hdl/dsag_addr.sv
// mixed-radix counters and destination address sum
`timescale 1ns / 1ps
`default_nettype none

module dsag_addr
    import dsag_pkg::*;
#(
    parameter int ADDR_WIDTH = 20
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire cfg_t                      cfg,
    input  wire logic [ADDR_WIDTH-1:0]     mid_swap,
    input  wire logic [ADDR_WIDTH-1:0]     block_step,
    output logic      [OUT_ADDR_WIDTH-1:0] dest_addr,
    output logic                           last_element
);

    logic [INDEX_WIDTH-1:0] first_index_reg,  first_index_next;
    logic [INDEX_WIDTH-1:0] middle_index_reg, middle_index_next;
    logic [INDEX_WIDTH-1:0] swap_index_reg,   swap_index_next;
    logic [SIZE_WIDTH-1:0]  items_seen_reg,   items_seen_next;
    logic [ADDR_WIDTH-1:0]  first_offset_reg,  first_offset_next;
    logic [ADDR_WIDTH-1:0]  middle_offset_reg, middle_offset_next;
    logic [ADDR_WIDTH-1:0]  block_base_reg,    block_base_next;

    logic [ADDR_WIDTH+INDEX_WIDTH-1:0] swap_ext;
    logic [ADDR_WIDTH+SIZE_WIDTH-1:0]  size_swap_ext;
    logic [ADDR_WIDTH-1:0]             dest_full;
    logic [ADDR_WIDTH+OUT_ADDR_WIDTH-1:0] dest_ext;
    logic [SIZE_WIDTH:0]               items_inc;
    logic [SIZE_WIDTH-1:0]             first_inc;
    logic [SIZE_WIDTH-1:0]             middle_inc;
    logic [SIZE_WIDTH-1:0]             swap_inc;
    logic                              first_wrap;
    logic                              middle_wrap;
    logic                              swap_wrap;

    // destination address, modulo the address width
    always_comb
    begin
        swap_ext      = {{ADDR_WIDTH{1'b0}}, swap_index_reg};
        size_swap_ext = {{ADDR_WIDTH{1'b0}}, cfg.size_swap};
        dest_full     = swap_ext[ADDR_WIDTH-1:0] + middle_offset_reg
                        + first_offset_reg + block_base_reg;
        dest_ext      = {{OUT_ADDR_WIDTH{1'b0}}, dest_full};
        dest_addr     = dest_ext[OUT_ADDR_WIDTH-1:0];
    end

    // wrap tests, a size of zero acts as one
    always_comb
    begin
        items_inc    = {1'b0, items_seen_reg} + 1'b1;
        first_inc    = {1'b0, first_index_reg} + 1'b1;
        middle_inc   = {1'b0, middle_index_reg} + 1'b1;
        swap_inc     = {1'b0, swap_index_reg} + 1'b1;
        last_element = items_inc >= {1'b0, cfg.element_count};
        first_wrap   = first_inc >= cfg.size_first;
        middle_wrap  = middle_inc >= cfg.size_middle;
        swap_wrap    = swap_inc >= cfg.size_swap;
    end

    // counter advance for one element
    always_comb
    begin
        first_index_next   = first_index_reg;
        middle_index_next  = middle_index_reg;
        swap_index_next    = swap_index_reg;
        items_seen_next    = items_seen_reg;
        first_offset_next  = first_offset_reg;
        middle_offset_next = middle_offset_reg;
        block_base_next    = block_base_reg;
        if (step)
        begin
            if (last_element)
            begin
                first_index_next   = '0;
                middle_index_next  = '0;
                swap_index_next    = '0;
                items_seen_next    = '0;
                first_offset_next  = '0;
                middle_offset_next = '0;
                block_base_next    = '0;
            end
            else
            begin
                items_seen_next = items_inc[SIZE_WIDTH-1:0];
                if (!first_wrap)
                begin
                    first_index_next  = first_inc[INDEX_WIDTH-1:0];
                    first_offset_next = first_offset_reg + mid_swap;
                end
                else
                begin
                    first_index_next  = '0;
                    first_offset_next = '0;
                    if (!middle_wrap)
                    begin
                        middle_index_next  = middle_inc[INDEX_WIDTH-1:0];
                        middle_offset_next = middle_offset_reg
                                             + size_swap_ext[ADDR_WIDTH-1:0];
                    end
                    else
                    begin
                        middle_index_next  = '0;
                        middle_offset_next = '0;
                        if (swap_wrap)
                        begin
                            swap_index_next = '0;
                            block_base_next = block_base_reg + block_step;
                        end
                        else
                        begin
                            swap_index_next = swap_inc[INDEX_WIDTH-1:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_index_reg   <= '0;
            middle_index_reg  <= '0;
            swap_index_reg    <= '0;
            items_seen_reg    <= '0;
            first_offset_reg  <= '0;
            middle_offset_reg <= '0;
            block_base_reg    <= '0;
        end
        else
        begin
            first_index_reg   <= first_index_next;
            middle_index_reg  <= middle_index_next;
            swap_index_reg    <= swap_index_next;
            items_seen_reg    <= items_seen_next;
            first_offset_reg  <= first_offset_next;
            middle_offset_reg <= middle_offset_next;
            block_base_reg    <= block_base_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dimension_swap_address_generator.sv
// top level of the dimension swap address generator
`timescale 1ns / 1ps
`default_nettype none

// Streams array elements in source order (first dimension fastest) and gives
// each one back with its address in the layout where the chosen dimension and
// dimension one trade places. One element is taken every clock cycle while the
// output is not stalled; a result passes through the input register, then the
// result register. While a result waits, the input register still takes one
// more element, and after that the input stalls until the result transfers.
// last_element marks the element numbered element_count, after which the
// counters restart at zero. Strides are derived from the size registers by
// multipliers in the register block. The element and middle strides are ready
// at the write transfer; the block stride follows from the stored sizes.
// Address arithmetic wraps modulo 2^ADDR_WIDTH.
module dimension_swap_address_generator
    import dsag_pkg::*;
#(
    parameter int ADDR_WIDTH = 20
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic        [APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic        [APB_DATA_WIDTH-1:0] pwdata,
    output logic             [APB_DATA_WIDTH-1:0] prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [DATA_WIDTH-1:0]  data_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic             [OUT_ADDR_WIDTH-1:0] dest_addr,
    output logic signed      [DATA_WIDTH-1:0]  out_value,
    output logic                               last_element
);

    cfg_t                  cfg;
    logic [ADDR_WIDTH-1:0] mid_swap;
    logic [ADDR_WIDTH-1:0] block_step;

    logic                         s1_valid_reg, s1_valid_next;
    logic signed [DATA_WIDTH-1:0] s1_data_reg;
    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] out_value_reg;
    logic [OUT_ADDR_WIDTH-1:0]    dest_addr_reg;
    logic                         last_reg;

    logic                      in_xfer;
    logic                      out_free;
    logic                      step;
    logic [OUT_ADDR_WIDTH-1:0] dest_comb;
    logic                      last_comb;

    // register block
    dsag_cfg #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg),
        .mid_swap   (mid_swap),
        .block_step (block_step)
    );

    // address unit, advances when the input register moves on
    dsag_addr #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .cfg          (cfg),
        .mid_swap     (mid_swap),
        .block_step   (block_step),
        .dest_addr    (dest_comb),
        .last_element (last_comb)
    );

    // pipeline handshake
    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        step     = s1_valid_reg && out_free;
        in_ready = !s1_valid_reg || out_free;
        in_xfer  = in_valid && in_ready;

        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (step)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_data_reg <= data_value;
        end
        if (step)
        begin
            out_value_reg <= s1_data_reg;
            dest_addr_reg <= dest_comb;
            last_reg      <= last_comb;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign dest_addr    = dest_addr_reg;
    assign last_element = last_reg;

    // an element leaving the input register always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
    else $error("result register empty after a stage advance");

    // an empty result register never stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
    else $error("input stalled with result register empty");

    // a stalled input register keeps its element
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_data_reg)))
    else $error("input register lost a stalled element");

endmodule

`default_nettype wire
